[rtl/nearest_probe_select_defines.svh]
// ----------------------------------------------------------------------------
// nearest_probe_select_defines
// assertion macros used by the checker file of the probe selector
// ----------------------------------------------------------------------------
`ifndef NEAREST_PROBE_SELECT_DEFINES_SVH
`define NEAREST_PROBE_SELECT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// codes, field layout and control types of the nearest probe selector
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int CHOICE_W   = 2;
  localparam int IDX_OUT_W  = 4;
  localparam int OUT_DATA_W = 16;

  // result word layout, lowest bit first
  localparam int OUT_FULL_LSB = 0;
  localparam int OUT_LCH_LSB  = OUT_FULL_LSB + 1;
  localparam int OUT_LIDX_LSB = OUT_LCH_LSB + CHOICE_W;
  localparam int OUT_RCH_LSB  = OUT_LIDX_LSB + IDX_OUT_W;
  localparam int OUT_RIDX_LSB = OUT_RCH_LSB + CHOICE_W;
  localparam int OUT_USED_W   = OUT_RIDX_LSB + IDX_OUT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_LIGHT = 2'd0,
    FUNC_ADD_REFL  = 2'd1,
    FUNC_QUERY     = 2'd2
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEAREST  = 2'd0,
    MODE_FALLBACK = 2'd1,
    MODE_NONE     = 2'd2
  } mode_e;

  typedef enum logic [CHOICE_W-1:0] {
    CHOICE_NONE     = 2'd0,
    CHOICE_INDEX    = 2'd1,
    CHOICE_FALLBACK = 2'd2
  } choice_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // per-entry sequence: compare previous distance, then one axis a cycle
  typedef enum logic [1:0] {
    PH_CMP,
    PH_X,
    PH_Y,
    PH_Z
  } phase_e;

  typedef struct packed {
    logic clear;
    logic mac_first;
    logic mac_en;
    logic cmp_en;
  } dist_ctl_t;

endpackage

[rtl/nps_dist_unit.sv]
// ----------------------------------------------------------------------------
// nps_dist_unit
// squared distance accumulator with running minimum, one axis per cycle
// ----------------------------------------------------------------------------
module nps_dist_unit import nps_pkg::*; #(
  parameter int CW = 16,
  parameter int IW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dist_ctl_t            ctl_i,
  input  logic        [CW-1:0] probe_i,
  input  logic        [CW-1:0] query_i,
  input  logic        [IW-1:0] idx_i,
  output logic        [IW-1:0] best_idx_o
);

  localparam int ACC_W = 2 * CW + 2;

  logic [CW:0]      diff;
  logic [CW:0]      mag;
  logic [ACC_W-1:0] mag_ext;
  logic [ACC_W-1:0] sq;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] best_q;
  logic [IW-1:0]    acc_idx_q;
  logic [IW-1:0]    best_idx_q;
  logic             found_q;
  logic             take;

  always_comb begin
    diff    = {probe_i[CW-1], probe_i} - {query_i[CW-1], query_i};
    mag     = diff[CW] ? ((~diff) + {{CW{1'b0}}, 1'b1}) : diff;
    mag_ext = ACC_W'(mag);
    sq      = mag_ext * mag_ext;
    acc_d   = ctl_i.mac_first ? sq : (acc_q + sq);
    // first entry always taken, afterwards strictly smaller only
    take    = ctl_i.cmp_en && (!found_q || (acc_q < best_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mac_en) begin
      acc_q <= acc_d;
    end
    if (ctl_i.mac_first) begin
      acc_idx_q <= idx_i;
    end
    if (take) begin
      best_q     <= acc_q;
      best_idx_q <= acc_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  assign best_idx_o = best_idx_q;

endmodule

[rtl/nearest_probe_select.sv]
// ----------------------------------------------------------------------------
// nearest_probe_select
// light and reflection probe tables with nearest probe lookup
// ----------------------------------------------------------------------------
// Two tables of up to MAX_PROBES probe positions are filled by add words
// (tuser selects add light, add reflection or query; tdata carries x, y, z).
// An add, a query outside nearest mode and an unused code give their result
// word in the cycle after acceptance. A nearest mode query walks both tables
// together, entry by entry (one distance compare, then one squared axis per
// cycle through the single multiplier of each table's distance unit), and
// its result word is loaded once the scan ends and the output register is
// free. Input is taken only while no query is in progress and the output
// register is free or being drained.
module nearest_probe_select import nps_pkg::*; #(
  parameter int MAX_PROBES = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // pos_x, pos_y, pos_z, zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0]                       s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // table_full, light_choice, light_index, refl_choice, refl_index, zero pad
  output logic [OUT_DATA_W-1:0]                   m_axis_tdata,
  input  logic                                    cfg_we_i,
  input  logic [MODE_W-1:0]                       cfg_wdata_i
);

  localparam int IW    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int CNT_W = $clog2(MAX_PROBES + 1);
  localparam int POS_W = 3 * COORD_BITS;
  localparam int CW    = COORD_BITS;

  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  mode_e                  mode_q;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [CNT_W-1:0]       light_cnt_q, light_cnt_d;
  logic [CNT_W-1:0]       refl_cnt_q, refl_cnt_d;
  logic                   light_pend_q, light_pend_d;
  logic                   refl_pend_q, refl_pend_d;
  logic [POS_W-1:0]       qpos_q;

  logic [POS_W-1:0]       light_mem [MAX_PROBES];
  logic [POS_W-1:0]       refl_mem  [MAX_PROBES];
  logic [POS_W-1:0]       light_rd_q;
  logic [POS_W-1:0]       refl_rd_q;

  logic                   m_valid_q;
  logic [OUT_DATA_W-1:0]  m_data_q;

  func_e                  func;
  logic                   in_acc;
  logic                   out_free;
  logic                   light_full, refl_full;
  logic                   light_we, refl_we;
  logic                   light_act, refl_act;
  logic                   scan_end;

  dist_ctl_t              light_ctl, refl_ctl;
  logic [CW-1:0]          light_coord, refl_coord, query_coord;
  logic [IW-1:0]          light_best, refl_best;

  logic                   out_load;
  logic                   o_full;
  choice_e                o_lch, o_rch;
  logic [IDX_OUT_W-1:0]   o_lidx, o_ridx;

  assign func       = func_e'(s_axis_tuser);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign light_full = (light_cnt_q >= CNT_W'(MAX_PROBES));
  assign refl_full  = (refl_cnt_q >= CNT_W'(MAX_PROBES));
  assign light_we   = in_acc && (func == FUNC_ADD_LIGHT) && !light_full;
  assign refl_we    = in_acc && (func == FUNC_ADD_REFL) && !refl_full;
  assign light_act  = (ptr_q < light_cnt_q);
  assign refl_act   = (ptr_q < refl_cnt_q);
  assign scan_end   = !light_act && !refl_act;

  // probe tables, one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (light_we) begin
      light_mem[light_cnt_q[IW-1:0]] <= s_axis_tdata[POS_W-1:0];
    end
    light_rd_q <= light_mem[ptr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (refl_we) begin
      refl_mem[refl_cnt_q[IW-1:0]] <= s_axis_tdata[POS_W-1:0];
    end
    refl_rd_q <= refl_mem[ptr_q[IW-1:0]];
  end

  // axis select for the distance units
  always_comb begin
    case (phase_q)
      PH_Y: begin
        light_coord = light_rd_q[2*CW-1:CW];
        refl_coord  = refl_rd_q[2*CW-1:CW];
        query_coord = qpos_q[2*CW-1:CW];
      end
      PH_Z: begin
        light_coord = light_rd_q[3*CW-1:2*CW];
        refl_coord  = refl_rd_q[3*CW-1:2*CW];
        query_coord = qpos_q[3*CW-1:2*CW];
      end
      default: begin
        light_coord = light_rd_q[CW-1:0];
        refl_coord  = refl_rd_q[CW-1:0];
        query_coord = qpos_q[CW-1:0];
      end
    endcase
  end

  // next state
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    ptr_d        = ptr_q;
    light_cnt_d  = light_cnt_q;
    refl_cnt_d   = refl_cnt_q;
    light_pend_d = light_pend_q;
    refl_pend_d  = refl_pend_q;
    case (state_q)
      S_IDLE: begin
        if (light_we) begin
          light_cnt_d = light_cnt_q + 1'b1;
        end
        if (refl_we) begin
          refl_cnt_d = refl_cnt_q + 1'b1;
        end
        if (in_acc && (func == FUNC_QUERY) && (mode_q == MODE_NEAREST)) begin
          state_d      = S_SCAN;
          phase_d      = PH_CMP;
          ptr_d        = '0;
          light_pend_d = 1'b0;
          refl_pend_d  = 1'b0;
        end
      end
      S_SCAN: begin
        case (phase_q)
          PH_CMP: begin
            if (scan_end) begin
              state_d = S_DONE;
            end else begin
              phase_d = PH_X;
            end
          end
          PH_X: phase_d = PH_Y;
          PH_Y: phase_d = PH_Z;
          PH_Z: begin
            light_pend_d = light_act;
            refl_pend_d  = refl_act;
            ptr_d        = ptr_q + 1'b1;
            phase_d      = PH_CMP;
          end
          default: phase_d = PH_CMP;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == S_IDLE) && out_free;
    light_ctl     = '0;
    refl_ctl      = '0;
    out_load      = 1'b0;
    o_full        = 1'b0;
    o_lch         = CHOICE_NONE;
    o_rch         = CHOICE_NONE;
    o_lidx        = '0;
    o_ridx        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_ADD_LIGHT: begin
              out_load = 1'b1;
              o_full   = light_full;
            end
            FUNC_ADD_REFL: begin
              out_load = 1'b1;
              o_full   = refl_full;
            end
            FUNC_QUERY: begin
              case (mode_q)
                MODE_NEAREST: begin
                  light_ctl.clear = 1'b1;
                  refl_ctl.clear  = 1'b1;
                end
                MODE_FALLBACK: begin
                  out_load = 1'b1;
                  o_lch    = CHOICE_FALLBACK;
                  o_rch    = CHOICE_FALLBACK;
                end
                default: out_load = 1'b1;
              endcase
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        case (phase_q)
          PH_CMP: begin
            light_ctl.cmp_en = light_pend_q;
            refl_ctl.cmp_en  = refl_pend_q;
          end
          PH_X: begin
            light_ctl.mac_first = light_act;
            light_ctl.mac_en    = light_act;
            refl_ctl.mac_first  = refl_act;
            refl_ctl.mac_en     = refl_act;
          end
          default: begin
            light_ctl.mac_en = light_act;
            refl_ctl.mac_en  = refl_act;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (light_cnt_q == '0) begin
            o_lch = CHOICE_FALLBACK;
          end else begin
            o_lch  = CHOICE_INDEX;
            o_lidx = IDX_OUT_W'(light_best);
          end
          if (refl_cnt_q == '0) begin
            o_rch = CHOICE_FALLBACK;
          end else begin
            o_rch  = CHOICE_INDEX;
            o_ridx = IDX_OUT_W'(refl_best);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_CMP;
      mode_q       <= MODE_NEAREST;
      ptr_q        <= '0;
      light_cnt_q  <= '0;
      refl_cnt_q   <= '0;
      light_pend_q <= 1'b0;
      refl_pend_q  <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      ptr_q        <= ptr_d;
      light_cnt_q  <= light_cnt_d;
      refl_cnt_q   <= refl_cnt_d;
      light_pend_q <= light_pend_d;
      refl_pend_q  <= refl_pend_d;
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qpos_q <= s_axis_tdata[POS_W-1:0];
    end
    if (out_load) begin
      m_data_q <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, o_ridx, o_rch, o_lidx, o_lch, o_full};
    end
  end

  nps_dist_unit #(
    .CW (CW),
    .IW (IW)
  ) u_light_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (light_ctl),
    .probe_i    (light_coord),
    .query_i    (query_coord),
    .idx_i      (ptr_q[IW-1:0]),
    .best_idx_o (light_best)
  );

  nps_dist_unit #(
    .CW (CW),
    .IW (IW)
  ) u_refl_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (refl_ctl),
    .probe_i    (refl_coord),
    .query_i    (query_coord),
    .idx_i      (ptr_q[IW-1:0]),
    .best_idx_o (refl_best)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/nps_checker.sv]
// ----------------------------------------------------------------------------
// nps_checker
// port-level checks of the nearest probe selector, bound to its top level
// ----------------------------------------------------------------------------
`include "nearest_probe_select_defines.svh"

module nps_checker import nps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result word stays put
  `NPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // no new word taken while the result register is blocked
  `NPS_ASSERT_NOW(a_no_take_when_blocked, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken with result register blocked")

  // a dropped add carries no selection
  `NPS_ASSERT_NOW(a_full_no_choice, m_axis_tvalid && m_axis_tdata[OUT_FULL_LSB], m_axis_tdata[OUT_USED_W-1:OUT_LCH_LSB] == '0, "table_full with a selection")

  // an index is only shown with an index choice
  `NPS_ASSERT_NOW(a_idx_needs_choice, m_axis_tvalid, (m_axis_tdata[OUT_LCH_LSB +: CHOICE_W] == CHOICE_INDEX || m_axis_tdata[OUT_LIDX_LSB +: IDX_OUT_W] == '0) && (m_axis_tdata[OUT_RCH_LSB +: CHOICE_W] == CHOICE_INDEX || m_axis_tdata[OUT_RIDX_LSB +: IDX_OUT_W] == '0), "index without index choice")

endmodule

bind nearest_probe_select nps_checker u_nps_checker (.*);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the nearest probe selector
// ----------------------------------------------------------------------------
// Add, query and unused words go in on the slave stream. Each accepted word
// updates a local copy of both probe tables, and the result word that copy
// and the mode copy give is queued. Every result on the master stream is
// checked field by field against the oldest queued one. Both streams idle at
// random. The mode register is rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module testbench;
  import nps_pkg::*;

  localparam int NUM_PROBES    = 16;
  localparam int COORD_W       = 16;
  localparam int IN_DATA_W     = ((3*COORD_W+7)/8)*8;
  localparam int MAX_GAP       = 12;
  localparam int SETTLE_CYCLES = 4*NUM_PROBES + 16;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_WORDS   = 123;
  localparam int MAX_REPORTS   = 40;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MIN = 16'sh8000;
  localparam coord_t COORD_MAX = 16'sh7fff;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    bit                drain_first;
  } probe_word_t;

  typedef struct packed {
    logic                 full;
    logic [CHOICE_W-1:0]  lch;
    logic [IDX_OUT_W-1:0] lidx;
    logic [CHOICE_W-1:0]  rch;
    logic [IDX_OUT_W-1:0] ridx;
  } selection_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic [FUNC_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [MODE_W-1:0]    cfg_wdata_i   = '0;

  // local copy of the block state: table 0 light, table 1 reflection
  coord_t            tab_pos [2][NUM_PROBES][3];
  int                tab_cnt [2];
  logic [MODE_W-1:0] cur_mode;

  probe_word_t pending_words[$];
  selection_t  expected_sel[$];
  point_t      seen_pts[$];

  int words_sent, words_taken, results_taken, results_seen;
  int in_gap, out_stall;
  bit in_burst, out_burst;
  int fails;
  int n_adds, n_drops, n_queries, n_unused, n_mode_writes;
  probe_word_t next_word, taken_word;
  selection_t  got_sel, want_sel;

  nearest_probe_select #(
    .MAX_PROBES (NUM_PROBES),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("nearest_probe_select: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sq_dist(int t, int i, coord_t x, coord_t y, coord_t z);
    longint dx, dy, dz;
    dx = longint'(tab_pos[t][i][0]) - longint'(x);
    dy = longint'(tab_pos[t][i][1]) - longint'(y);
    dz = longint'(tab_pos[t][i][2]) - longint'(z);
    return dx*dx + dy*dy + dz*dz;
  endfunction

  function automatic void nearest_entry(input int t, input coord_t x, input coord_t y,
                                        input coord_t z, output logic [CHOICE_W-1:0] ch,
                                        output logic [IDX_OUT_W-1:0] idx);
    longint best_d, d;
    int best;
    idx = '0;
    if (tab_cnt[t] == 0) begin
      ch = CHOICE_FALLBACK;
    end else begin
      best   = 0;
      best_d = sq_dist(t, 0, x, y, z);
      // strict compare keeps the lowest index on equal distances
      for (int i = 1; i < tab_cnt[t]; i++) begin
        d = sq_dist(t, i, x, y, z);
        if (d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      ch  = CHOICE_INDEX;
      idx = best[IDX_OUT_W-1:0];
    end
  endfunction

  function automatic selection_t predict_selection(probe_word_t w);
    selection_t r;
    int t;
    r = '0;
    case (w.func)
      FUNC_ADD_LIGHT, FUNC_ADD_REFL: begin
        t = (w.func == FUNC_ADD_REFL) ? 1 : 0;
        n_adds++;
        if (tab_cnt[t] >= NUM_PROBES) begin
          r.full = 1'b1;
          n_drops++;
        end else begin
          tab_pos[t][tab_cnt[t]][0] = w.x;
          tab_pos[t][tab_cnt[t]][1] = w.y;
          tab_pos[t][tab_cnt[t]][2] = w.z;
          tab_cnt[t]++;
        end
      end
      FUNC_QUERY: begin
        n_queries++;
        case (cur_mode)
          MODE_NEAREST: begin
            nearest_entry(0, w.x, w.y, w.z, r.lch, r.lidx);
            nearest_entry(1, w.x, w.y, w.z, r.rch, r.ridx);
          end
          MODE_FALLBACK: begin
            r.lch = CHOICE_FALLBACK;
            r.rch = CHOICE_FALLBACK;
          end
          default: ;
        endcase
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          3:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      // tight cluster around the origin makes ties common
      1, 2:    return coord_t'(int'($urandom_range(0, 8)) - 4);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  function automatic point_t near_point();
    point_t p;
    p   = seen_pts[$urandom_range(0, seen_pts.size() - 1)];
    p.x = coord_t'(int'(p.x) + int'($urandom_range(0, 6)) - 3);
    p.y = coord_t'(int'(p.y) + int'($urandom_range(0, 6)) - 3);
    p.z = coord_t'(int'(p.z) + int'($urandom_range(0, 6)) - 3);
    return p;
  endfunction

  function automatic probe_word_t make_random_word(int add_pct);
    probe_word_t w;
    point_t p;
    int roll;
    roll = $urandom_range(0, 99);
    p    = rand_point();
    if (roll < add_pct) begin
      w.func = $urandom_range(0, 1) ? FUNC_ADD_REFL : FUNC_ADD_LIGHT;
      // repeated positions give equal distances
      if (seen_pts.size() > 0 && $urandom_range(0, 3) == 0)
        p = seen_pts[$urandom_range(0, seen_pts.size() - 1)];
    end else if (roll < add_pct + 3) begin
      w.func = FUNC_UNUSED;
    end else begin
      w.func = FUNC_QUERY;
      if (seen_pts.size() > 0) begin
        case ($urandom_range(0, 2))
          0:       p = near_point();
          1:       p = seen_pts[$urandom_range(0, seen_pts.size() - 1)];
          default: ;
        endcase
      end
    end
    w.x           = p.x;
    w.y           = p.y;
    w.z           = p.z;
    w.drain_first = ($urandom_range(0, 59) == 0);
    return w;
  endfunction

  task automatic queue_word(logic [FUNC_W-1:0] func, coord_t x, coord_t y, coord_t z,
                            bit drain_first = 1'b0);
    probe_word_t w;
    point_t p;
    w = '{func, x, y, z, drain_first};
    pending_words.insert(pending_words.size(), w);
    if (func == FUNC_ADD_LIGHT || func == FUNC_ADD_REFL) begin
      p = '{x, y, z};
      seen_pts.insert(seen_pts.size(), p);
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_sel.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] mode);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    cur_mode     = mode;
    n_mode_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0] phase_modes [NUM_PHASES];
    probe_word_t w;
    phase_modes = '{MODE_NEAREST, MODE_NEAREST, MODE_FALLBACK, MODE_NEAREST, MODE_NONE,
                    MODE_NEAREST, MODE_UNUSED, MODE_NEAREST, MODE_FALLBACK, MODE_NEAREST};
    cur_mode   = MODE_NEAREST;
    tab_cnt[0] = 0;
    tab_cnt[1] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty tables, coordinate extremes, ties, every code and mode
    queue_word(FUNC_QUERY,     16'sd0,    16'sd0,    16'sd0);
    queue_word(FUNC_ADD_LIGHT, COORD_MAX, COORD_MIN, 16'sd0);
    queue_word(FUNC_QUERY,     16'sd5,    -16'sd5,   16'sd5);
    queue_word(FUNC_ADD_LIGHT, COORD_MIN, COORD_MAX, -16'sd1);
    queue_word(FUNC_ADD_LIGHT, COORD_MAX, COORD_MIN, 16'sd0);
    queue_word(FUNC_ADD_REFL,  16'sd1,    16'sd1,    16'sd1);
    queue_word(FUNC_ADD_REFL,  -16'sd1,   -16'sd1,   -16'sd1);
    queue_word(FUNC_QUERY,     COORD_MAX, COORD_MIN, 16'sd0, 1'b1);
    queue_word(FUNC_QUERY,     16'sd0,    16'sd0,    16'sd0);
    queue_word(FUNC_QUERY,     COORD_MIN, COORD_MAX, COORD_MIN);
    queue_word(FUNC_QUERY,     COORD_MAX, COORD_MAX, COORD_MAX);
    queue_word(FUNC_UNUSED,    -16'sd1,   -16'sd1,   -16'sd1);
    wait_idle();
    write_mode(MODE_FALLBACK);
    queue_word(FUNC_QUERY,     16'sd1,    16'sd1,    16'sd1);
    queue_word(FUNC_ADD_REFL,  16'sd0,    16'sd0,    16'sd0);
    queue_word(FUNC_QUERY,     COORD_MIN, COORD_MIN, COORD_MIN);
    wait_idle();
    write_mode(MODE_NONE);
    queue_word(FUNC_QUERY,     16'sd0,    16'sd0,    16'sd0);
    queue_word(FUNC_ADD_LIGHT, 16'sd2,    -16'sd3,   16'sd4);
    wait_idle();
    write_mode(MODE_UNUSED);
    queue_word(FUNC_QUERY,     16'sd0,    16'sd0,    16'sd0);
    queue_word(FUNC_UNUSED,    16'sd0,    16'sd0,    16'sd0);
    wait_idle();
    write_mode(MODE_NEAREST);
    queue_word(FUNC_QUERY,     16'sd1,    -16'sd1,   16'sd1);
    wait_idle();

    // random phases; the first fills both tables past the limit
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(phase_modes[ph]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        w = make_random_word(ph == 0 ? 45 : 12);
        queue_word(w.func, w.x, w.y, w.z, w.drain_first);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_sel.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, expected_sel.size());
      fails++;
    end
    $display("run covered %0d words: %0d adds (%0d dropped on a full table), %0d queries,",
             words_taken, n_adds, n_drops, n_queries);
    $display("%0d unused codes, %0d mode writes over all four settings, %0d results checked",
             n_unused, n_mode_writes, results_taken);
    if (fails == 0) begin
      $display("nearest_probe_select: match");
    end else begin
      $display("nearest_probe_select: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && words_taken != words_sent)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   (!pending_words[0].drain_first || expected_sel.size() == 0)) begin
        next_word = pending_words.pop_front();
        s_axis_tuser  <= next_word.func;
        s_axis_tdata  <= {next_word.z, next_word.y, next_word.x};
        s_axis_tvalid <= 1'b1;
        words_sent++;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side stalls, drawn afresh for every word taken
  always @(negedge clk_i) begin
    if (results_seen != results_taken) begin
      results_seen = results_taken;
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitors

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken_word.func        = s_axis_tuser;
      taken_word.x           = s_axis_tdata[0 +: COORD_W];
      taken_word.y           = s_axis_tdata[COORD_W +: COORD_W];
      taken_word.z           = s_axis_tdata[2*COORD_W +: COORD_W];
      taken_word.drain_first = 1'b0;
      expected_sel.insert(expected_sel.size(), predict_selection(taken_word));
      words_taken++;
    end
  end

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      got_sel.full = m_axis_tdata[OUT_FULL_LSB];
      got_sel.lch  = m_axis_tdata[OUT_LCH_LSB +: CHOICE_W];
      got_sel.lidx = m_axis_tdata[OUT_LIDX_LSB +: IDX_OUT_W];
      got_sel.rch  = m_axis_tdata[OUT_RCH_LSB +: CHOICE_W];
      got_sel.ridx = m_axis_tdata[OUT_RIDX_LSB +: IDX_OUT_W];
      if (expected_sel.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: result word %h with none expected", $time, m_axis_tdata);
      end else begin
        want_sel = expected_sel.pop_front();
        check_field("table_full",   want_sel.full, got_sel.full);
        check_field("light_choice", want_sel.lch,  got_sel.lch);
        check_field("light_index",  want_sel.lidx, got_sel.lidx);
        check_field("refl_choice",  want_sel.rch,  got_sel.rch);
        check_field("refl_index",   want_sel.ridx, got_sel.ridx);
      end
    end
  end

endmodule

[files.f]
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_dist_unit.sv
rtl/nearest_probe_select.sv
rtl/nps_checker.sv
bench/testbench.sv
